@@ hdl/udrb_pkg.sv @@
// shared types and codes for the uart dual ring buffer
// no dependencies; imported by the controller, datapath and top level
package udrb_pkg;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 3'd0,
    ACT_READ  = 3'd1,
    ACT_RX    = 3'd2,
    ACT_TXE   = 3'd3,
    ACT_CLEAR = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic step;       // accept the current beat and update the queues
    logic load_byte;  // capture popped byte from ram into the result register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_valid;  // result register holds a beat not yet taken
    logic pop_hit;    // current beat pops a byte from one of the rams
  } dp_status_t;

endpackage

@@ hdl/udrb_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module udrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/udrb_ctrl.sv @@
// controller for the uart dual ring buffer: input handshake and fetch sequencing
// depends on udrb_pkg
module udrb_ctrl
  import udrb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic       m_tready_i,
  input  dp_status_t status_i,
  output logic       s_tready_o,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  // a new beat may enter while the previous result is being taken
  assign s_tready_o = (state_q == ST_IDLE) && (!status_i.out_valid || m_tready_i);
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    state_d         = state_q;
    cmd_o.step      = 1'b0;
    cmd_o.load_byte = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.step = 1'b1;
          if (status_i.pop_hit) begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd_o.load_byte = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/udrb_dp.sv @@
// datapath for the uart dual ring buffer: ring pointers, flags, both rams, result register
// depends on udrb_pkg and udrb_ram
module udrb_dp
  import udrb_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_cmd_t             cmd_i,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [IN_DATA_W-1:0]  data_i,
  input  logic                  m_tready_i,
  output dp_status_t            status_o,
  output logic                  m_tvalid_o,
  output logic [OUT_DATA_W-1:0] m_tdata_o
);

  localparam int unsigned PTR_W = $clog2(BUF_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUF_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  logic [PTR_W-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [PTR_W-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic             rx_ovf_q, rx_ovf_d;
  logic             tx_irq_q, tx_irq_d;

  logic             out_valid_q, out_valid_d;
  logic             out_ok_q, out_ok_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_notice_q, out_notice_d;
  logic             out_irq_q, out_irq_d;
  logic             out_ovf_q, out_ovf_d;
  logic             pop_tx_q, pop_tx_d;

  logic             rx_full, rx_empty, tx_full, tx_empty;
  logic             rx_we, rx_re, tx_we, tx_re;
  logic             ok, notice;
  logic [7:0]       rx_rdata, tx_rdata;
  action_e          action;

  assign action   = action_e'(action_i);
  assign rx_full  = (ptr_next(rx_head_q) == rx_tail_q);
  assign tx_full  = (ptr_next(tx_head_q) == tx_tail_q);
  assign rx_empty = (rx_tail_q == rx_head_q);
  assign tx_empty = (tx_tail_q == tx_head_q);

  always_comb begin
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    rx_ovf_d  = rx_ovf_q;
    tx_irq_d  = tx_irq_q;
    rx_we     = 1'b0;
    rx_re     = 1'b0;
    tx_we     = 1'b0;
    tx_re     = 1'b0;
    ok        = 1'b0;
    notice    = 1'b0;
    unique case (action)
      ACT_WRITE: begin
        if (!tx_full) begin
          tx_we     = 1'b1;
          tx_head_d = ptr_next(tx_head_q);
          tx_irq_d  = 1'b1;
          ok        = 1'b1;
        end
      end
      ACT_READ: begin
        // a pending overflow is reported before anything is popped
        if (rx_ovf_q) begin
          rx_ovf_d = 1'b0;
          ok       = 1'b1;
          notice   = 1'b1;
        end else if (!rx_empty) begin
          rx_re     = 1'b1;
          rx_tail_d = ptr_next(rx_tail_q);
          ok        = 1'b1;
        end
      end
      ACT_RX: begin
        if (!rx_full) begin
          rx_we     = 1'b1;
          rx_head_d = ptr_next(rx_head_q);
          ok        = 1'b1;
        end else begin
          rx_ovf_d = 1'b1;
        end
      end
      ACT_TXE: begin
        if (!tx_empty) begin
          tx_re     = 1'b1;
          tx_tail_d = ptr_next(tx_tail_q);
          ok        = 1'b1;
        end else begin
          tx_irq_d = 1'b0;
        end
      end
      ACT_CLEAR: begin
        rx_head_d = '0;
        rx_tail_d = '0;
        tx_head_d = '0;
        tx_tail_d = '0;
        rx_ovf_d  = 1'b0;
        tx_irq_d  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign status_o.pop_hit   = rx_re || tx_re;
  assign status_o.out_valid = out_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_ok_d     = out_ok_q;
    out_byte_d   = out_byte_q;
    out_notice_d = out_notice_q;
    out_irq_d    = out_irq_q;
    out_ovf_d    = out_ovf_q;
    pop_tx_d     = pop_tx_q;
    if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.step) begin
      out_ok_d     = ok;
      out_byte_d   = '0;
      out_notice_d = notice;
      out_irq_d    = tx_irq_d;
      out_ovf_d    = rx_ovf_d;
      pop_tx_d     = tx_re;
      // a pop waits in the fetch state for the registered ram read
      if (!(rx_re || tx_re)) begin
        out_valid_d = 1'b1;
      end
    end
    if (cmd_i.load_byte) begin
      out_byte_d  = pop_tx_q ? tx_rdata : rx_rdata;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      rx_ovf_q    <= 1'b0;
      tx_irq_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.step) begin
        rx_head_q <= rx_head_d;
        rx_tail_q <= rx_tail_d;
        tx_head_q <= tx_head_d;
        tx_tail_q <= tx_tail_d;
        rx_ovf_q  <= rx_ovf_d;
        tx_irq_q  <= tx_irq_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ok_q     <= out_ok_d;
    out_byte_q   <= out_byte_d;
    out_notice_q <= out_notice_d;
    out_irq_q    <= out_irq_d;
    out_ovf_q    <= out_ovf_d;
    pop_tx_q     <= pop_tx_d;
  end

  udrb_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.step && rx_we),
    .waddr_i (rx_head_q),
    .wdata_i (data_i),
    .re_i    (cmd_i.step && rx_re),
    .raddr_i (rx_tail_q),
    .rdata_o (rx_rdata)
  );

  udrb_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.step && tx_we),
    .waddr_i (tx_head_q),
    .wdata_i (data_i),
    .re_i    (cmd_i.step && tx_re),
    .raddr_i (tx_tail_q),
    .rdata_o (tx_rdata)
  );

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {4'b0000, out_ovf_q, out_irq_q, out_notice_q, out_byte_q, out_ok_q};

endmodule

@@ hdl/uart_dual_ring_buffer_top.sv @@
// top level of the uart dual ring buffer: controller plus datapath
// depends on udrb_pkg, udrb_ctrl, udrb_dp (and through it udrb_ram)

// Receive and transmit byte queues for a uart, each a ring of BUF_DEPTH bytes that holds up
// to BUF_DEPTH-1 entries. One input beat is one event (kind in tuser: cpu write, cpu read,
// line byte received, transmit register empty, clear buffers); each gives exactly one
// result beat. An event that pops a byte goes through the fetch state, since the byte comes
// through the registered read port of the queue ram, and no new event is taken in that
// state; any other event skips it. The result waits in an output register, and a new
// event is taken in the same cycle that the waiting result is taken. Ram contents are not
// cleared at reset or by a clear event; only the pointers and flags are.
module uart_dual_ring_buffer_top
  import udrb_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,   // [7:0] data_in
  input  logic [ACTION_W-1:0]   s_tuser_i,   // [2:0] action
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  // [0] ok, [8:1] byte_out, [9] overflow_notice, [10] tx_irq_on,
  // [11] overflow_pending, [15:12] zero
  output logic [OUT_DATA_W-1:0] m_tdata_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  udrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .m_tready_i (m_tready_i),
    .status_i   (status),
    .s_tready_o (s_tready_o),
    .cmd_o      (cmd)
  );

  udrb_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .action_i   (s_tuser_i),
    .data_i     (s_tdata_i),
    .m_tready_i (m_tready_i),
    .status_o   (status),
    .m_tvalid_o (m_tvalid_o),
    .m_tdata_o  (m_tdata_o)
  );

endmodule
